### rtl/xml_byte_tokenizer_assert.svh
// assertion macros for the xml byte tokenizer modules
// expects signals named clk and rst in the scope of each use
`ifndef XML_BYTE_TOKENIZER_ASSERT_SVH
`define XML_BYTE_TOKENIZER_ASSERT_SVH

// checked only outside reset
`define XBT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define XBT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/xbt_pkg.sv
// shared types and constants of the xml byte tokenizer
// used by xbt_front, xbt_queue, xbt_back and xml_byte_tokenizer; no dependencies
package xbt_pkg;

  localparam int MAX_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH   = 2;   // power of two
  localparam int DEPTH_W       = 7;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_TEXT_CHAR  = 4'd1,
    EV_TEXT_DONE  = 4'd2,
    EV_TAG_FIRST  = 4'd3,
    EV_TAG_CHAR   = 4'd4,
    EV_OPEN       = 4'd5,
    EV_CLOSE      = 4'd6,
    EV_ATTR_FIRST = 4'd7,
    EV_ATTR_CHAR  = 4'd8,
    EV_VALUE_CHAR = 4'd9,
    EV_ATTR_DONE  = 4'd10
  } event_t;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;

  // character class flags worked out in the front
  typedef struct packed {
    logic lt;
    logic gt;
    logic slash;
    logic qmark;
    logic bang;
    logic eq;
    logic quote;
    logic brk;     // cr or lf
    logic space;   // cr, lf or blank
    logic blank;   // plain space only
    logic letter;  // 'A'..'z'
  } char_class_t;

  typedef struct packed {
    logic [7:0]  char_byte;
    char_class_t cls;
  } entry_t;

endpackage

### rtl/xbt_front.sv
// front part: takes raw bytes and tags each with its character class
// depends on xbt_pkg
module xbt_front (
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,    // byte_in
  input  logic              q_full,
  output logic              q_push,
  output xbt_pkg::entry_t   q_entry
);

  xbt_pkg::char_class_t cls;

  always_comb begin
    cls.lt     = (s_tdata == xbt_pkg::CH_LT);
    cls.gt     = (s_tdata == xbt_pkg::CH_GT);
    cls.slash  = (s_tdata == xbt_pkg::CH_SLASH);
    cls.qmark  = (s_tdata == xbt_pkg::CH_QMARK);
    cls.bang   = (s_tdata == xbt_pkg::CH_BANG);
    cls.eq     = (s_tdata == xbt_pkg::CH_EQ);
    cls.quote  = (s_tdata == xbt_pkg::CH_QUOTE);
    cls.brk    = (s_tdata == xbt_pkg::CH_CR) || (s_tdata == xbt_pkg::CH_LF);
    cls.blank  = (s_tdata == xbt_pkg::CH_SP);
    cls.space  = cls.brk || cls.blank;
    cls.letter = (s_tdata >= xbt_pkg::CH_UC_A) && (s_tdata <= xbt_pkg::CH_LC_Z);
  end

  assign s_tready          = !q_full;
  assign q_push            = s_tvalid && !q_full;
  assign q_entry.char_byte = s_tdata;
  assign q_entry.cls       = cls;

endmodule

### rtl/xbt_queue.sv
// short queue of classified bytes between front and back
// depends on xbt_pkg and xml_byte_tokenizer_assert.svh
`include "xml_byte_tokenizer_assert.svh"

module xbt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  xbt_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output xbt_pkg::entry_t head_entry
);

  localparam int PTR_W = (xbt_pkg::QUEUE_DEPTH > 1) ? $clog2(xbt_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(xbt_pkg::QUEUE_DEPTH + 1);

  xbt_pkg::entry_t  slots [xbt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(xbt_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `XBT_ASSERT(a_count_bound, count <= CNT_W'(xbt_pkg::QUEUE_DEPTH), "queue count beyond depth")
  `XBT_ASSERT(a_pop_nonempty, pop |-> head_valid, "pop from empty queue")
  `XBT_ASSERT(a_ptr_gap, (count == '0) |-> (wr_ptr == rd_ptr), "pointers apart on empty queue")

endmodule

### rtl/xbt_back.sv
// back part: lexer state machine, depth counter and output register
// depends on xbt_pkg and xml_byte_tokenizer_assert.svh
`include "xml_byte_tokenizer_assert.svh"

module xbt_back #(
  parameter int MAX_DEPTH = xbt_pkg::MAX_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  xbt_pkg::entry_t head_entry,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [23:0]     m_tdata    // event_res, char_out, depth, overflow, zero pad
);

  localparam int DW = $clog2(MAX_DEPTH + 1);

  typedef enum logic [3:0] {
    S_SYNC, S_TAG, S_ENDTAG, S_DECL, S_DECL_NAME, S_DECL_END,
    S_DECL_BODY, S_DECL_BODY_END, S_COMMENT, S_NAME, S_INTAG,
    S_SKIP_TO_GT, S_ATTR_NAME, S_ATTR_EQ_WAIT, S_ATTR_QUOTE_WAIT, S_ATTR_VALUE
  } lex_state_t;

  lex_state_t           lex_state, lex_state_next;
  logic [DW-1:0]        nest_depth, nest_depth_next;
  logic                 text_pending, text_pending_next;
  logic                 value_pending, value_pending_next;
  xbt_pkg::event_t      ev;
  logic                 refused;

  xbt_pkg::event_t      event_res;
  logic [7:0]           char_out;
  logic [DW-1:0]        depth_cnt;
  logic                 overflow;
  logic [DW+6:0]        depth_wide;

  xbt_pkg::char_class_t c;
  logic                 advance;

  assign c       = head_entry.cls;
  assign advance = !m_tvalid || m_tready;
  assign pop     = head_valid && advance;

  always_comb begin
    lex_state_next     = lex_state;
    nest_depth_next    = nest_depth;
    text_pending_next  = text_pending;
    value_pending_next = value_pending;
    ev                 = xbt_pkg::EV_NONE;
    refused            = 1'b0;
    case (lex_state)
      S_SYNC: begin
        if (c.lt) begin
          if (text_pending) begin
            ev                = xbt_pkg::EV_TEXT_DONE;
            text_pending_next = 1'b0;
          end
          lex_state_next = S_TAG;
        end else if (nest_depth != '0 && !c.brk) begin
          ev                = xbt_pkg::EV_TEXT_CHAR;
          text_pending_next = 1'b1;
        end
      end
      S_TAG: begin
        if (c.slash) lex_state_next = S_ENDTAG;
        else if (c.qmark) lex_state_next = S_DECL;
        else if (c.bang) lex_state_next = S_COMMENT;
        else if (!c.space) begin
          ev             = xbt_pkg::EV_TAG_FIRST;
          lex_state_next = S_NAME;
        end
      end
      S_COMMENT: begin
        if (c.gt) lex_state_next = S_SYNC;
      end
      S_NAME: begin
        if (c.gt || c.space) begin
          ev = xbt_pkg::EV_OPEN;
          if (nest_depth < DW'(MAX_DEPTH)) nest_depth_next = nest_depth + 1'b1;
          else refused = 1'b1;
          lex_state_next = c.gt ? S_SYNC : S_INTAG;
        end else if (c.slash) lex_state_next = S_SKIP_TO_GT;
        else ev = xbt_pkg::EV_TAG_CHAR;
      end
      S_INTAG: begin
        if (c.gt) lex_state_next = S_SYNC;
        else if (c.slash) begin
          // empty element: close the one just opened
          if (nest_depth != '0) begin
            ev              = xbt_pkg::EV_CLOSE;
            nest_depth_next = nest_depth - 1'b1;
          end
          lex_state_next = S_SKIP_TO_GT;
        end else if (!c.space) begin
          ev             = xbt_pkg::EV_ATTR_FIRST;
          lex_state_next = S_ATTR_NAME;
        end
      end
      S_ATTR_NAME: begin
        if (c.gt) lex_state_next = S_SYNC;
        else if (c.space) lex_state_next = S_ATTR_EQ_WAIT;
        else if (c.eq) lex_state_next = S_ATTR_QUOTE_WAIT;
        else ev = xbt_pkg::EV_ATTR_CHAR;
      end
      S_ATTR_EQ_WAIT: begin
        if (c.gt) lex_state_next = S_SYNC;
        else if (c.eq) lex_state_next = S_ATTR_QUOTE_WAIT;
      end
      S_ATTR_QUOTE_WAIT: begin
        if (c.gt) lex_state_next = S_SYNC;
        else if (c.quote) begin
          value_pending_next = 1'b0;
          lex_state_next     = S_ATTR_VALUE;
        end
      end
      S_ATTR_VALUE: begin
        if (c.quote) begin
          if (value_pending) ev = xbt_pkg::EV_ATTR_DONE;
          value_pending_next = 1'b0;
          lex_state_next     = S_INTAG;
        end else begin
          ev                 = xbt_pkg::EV_VALUE_CHAR;
          value_pending_next = 1'b1;
        end
      end
      S_ENDTAG: begin
        if (c.gt || c.space) begin
          if (nest_depth != '0) begin
            ev              = xbt_pkg::EV_CLOSE;
            nest_depth_next = nest_depth - 1'b1;
          end
          lex_state_next = c.gt ? S_SYNC : S_SKIP_TO_GT;
        end
      end
      S_SKIP_TO_GT: begin
        if (c.gt) lex_state_next = S_SYNC;
      end
      S_DECL: begin
        if (c.qmark) lex_state_next = S_DECL_END;
        else if (c.letter) lex_state_next = S_DECL_NAME;
      end
      S_DECL_NAME: begin
        if (c.qmark) lex_state_next = S_DECL_END;
        else if (c.blank) lex_state_next = S_DECL_BODY;
      end
      S_DECL_END: begin
        lex_state_next = c.gt ? S_SYNC : S_DECL_NAME;
      end
      S_DECL_BODY: begin
        if (c.qmark) lex_state_next = S_DECL_BODY_END;
      end
      S_DECL_BODY_END: begin
        lex_state_next = c.gt ? S_SYNC : S_DECL_BODY;
      end
      default: begin
        lex_state_next = S_SYNC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_state     <= S_SYNC;
      nest_depth    <= '0;
      text_pending  <= 1'b0;
      value_pending <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (pop) begin
        lex_state     <= lex_state_next;
        nest_depth    <= nest_depth_next;
        text_pending  <= text_pending_next;
        value_pending <= value_pending_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      event_res <= ev;
      char_out  <= head_entry.char_byte;
      depth_cnt <= nest_depth_next;
      overflow  <= refused;
    end
  end

  assign depth_wide = (DW + 7)'(depth_cnt);
  assign m_tdata    = {4'b0, overflow, depth_wide[xbt_pkg::DEPTH_W-1:0], char_out, event_res};

  `XBT_ASSERT(a_depth_bound, nest_depth <= DW'(MAX_DEPTH), "nesting depth beyond maximum")
  `XBT_ASSERT(a_ovf_open, (m_tvalid && overflow) |-> (event_res == xbt_pkg::EV_OPEN && depth_cnt == DW'(MAX_DEPTH)), "overflow without open at maximum")
  `XBT_ASSERT(a_close_step, (pop && ev == xbt_pkg::EV_CLOSE) |=> (nest_depth == $past(nest_depth) - 1'b1), "close did not lower depth")

endmodule

### rtl/xml_byte_tokenizer.sv
// xml byte tokenizer: one event per input byte, 16-state lexer
// a byte accepted is written into the queue, then the lexer step in the back part registers its result on m_tdata
// throughput: one byte per cycle while m_tready does not stall the output, set by the lexer step in the back part
// rst (synchronous, active high) empties the queue and output register,
// returns the lexer to the text state and clears depth and pending flags
module xml_byte_tokenizer #(
  parameter int MAX_DEPTH = xbt_pkg::MAX_DEPTH_DEF   // 1 .. 127
) (
  input  logic        clk,
  input  logic        rst,
  // input byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  // event stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [3:0] event_res, [11:4] char_out, [18:12] depth,
                                 // [19] overflow, [23:20] zero
);

  // classified byte travelling from front to back
  xbt_pkg::entry_t push_entry;
  xbt_pkg::entry_t head_entry;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;

  // front: classifies each byte, stalls only when the queue is full
  xbt_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  // two-entry queue, push and pop in the same cycle keep the stream going
  xbt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  // back: lexer step, depth counter, registered result
  xbt_back #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_entry (head_entry),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
